/* src/gcd_pkg.sv */
// shared types, constants and the cordic arctangent table for the great-circle distance core
// depends on nothing; every other file of the core uses it by scoped name
package gcd_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 24;

    // port and datapath widths
    localparam int LAT_W      = 24;
    localparam int LNG_W      = 25;
    localparam int DIST_W     = 25;
    localparam int CFG_DATA_W = 25;
    localparam int DEG_W      = 26;
    localparam int MAG_W      = 25;
    localparam int PHASE_W    = 32;
    localparam int XW         = 34;
    localparam int ZW         = 34;
    localparam int TRIG_W     = 32;
    localparam int SQ_W       = 61;
    localparam int SQRT_STEPS = 31;
    localparam int PROD_W     = 58;
    localparam int CIRC_W     = 26;

    localparam int HALF_TURN_DEG = 180;
    localparam int DIVISOR       = 2 * HALF_TURN_DEG;
    // 360 = 8 * 45: the divide reduces to an odd divisor of 45 with a rounding term of 22
    localparam int DIV_ODD       = DIVISOR / 8;
    localparam int ROUND_ODD     = HALF_TURN_DEG / 8;

    // ceil(2^31 / 45), exact quotient by 45 for any 25-bit magnitude
    localparam int RECIP_W  = 26;
    localparam int RECIP_SH = 31;
    localparam int QA_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP_ODD = 26'd47721859;

    localparam logic [31:0]       GAIN_Q30        = 32'd652032875;
    localparam logic [31:0]       ONE_Q30         = 32'd1073741824;
    // 2*pi*6371 km in whole metres
    localparam logic [CIRC_W-1:0] CIRCUMFERENCE_M = 26'd40030174;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_M  = 25'd20015087;

    typedef enum logic [0:0] {
        CFG_OWN_LATITUDE  = 1'b0,
        CFG_OWN_LONGITUDE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_rot;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic [SQ_W-1:0]          n;
        logic [SQ_W-1:0]          r;
        logic signed [TRIG_W-1:0] c;
    } t_sqr;

    // atan(2^-i), full turn = 2^32
    function automatic logic [31:0] atan_phase(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* src/gcd_div_cell.sv */
// degree magnitude to binary phase, three registered steps: reciprocal multiply by 1/45,
// remainder, then quotient shift plus a 45-entry constant table; depends on gcd_pkg
module gcd_div_cell #(
    parameter int SH = 32 - gcd_pkg::ANGLE_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [gcd_pkg::MAG_W-1:0]   i_mag,
    input  logic                        i_neg,
    output logic [gcd_pkg::PHASE_W-1:0] o_phase,
    output logic                        o_neg
);
    localparam int MW = gcd_pkg::MAG_W;
    localparam int PW = gcd_pkg::PHASE_W;
    localparam int AW = gcd_pkg::QA_W;
    localparam int RW = gcd_pkg::RECIP_W;
    localparam int DO = gcd_pkg::DIV_ODD;
    // phase = floor((mag * 2^LS + 22) / 45) with LS = SH - 3
    localparam int LS = SH - 3;

    logic [PW-1:0]    w_tbl [DO];
    logic [AW-1:0]    w_a;
    logic [MW-1:0]    w_a45;
    logic [5:0]       w_b;

    logic [MW+RW-1:0] r_prod;
    logic [MW-1:0]    r_mag;
    logic             r_neg1;
    logic [AW-1:0]    r_a;
    logic [5:0]       r_b;
    logic             r_neg2;
    logic [PW-1:0]    r_phase;
    logic             r_neg3;

    // phase contribution of the remainder mag mod 45, with the rounding term folded in
    for (genvar g = 0; g < DO; g++) begin : g_tbl
        assign w_tbl[g] = PW'(((64'(g) << LS) + 64'(gcd_pkg::ROUND_ODD)) / 64'(DO));
    end

    assign w_a   = r_prod[gcd_pkg::RECIP_SH +: AW];
    assign w_a45 = MW'(w_a) * MW'(DO);
    assign w_b   = 6'(r_mag - w_a45);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= (MW+RW)'(i_mag) * (MW+RW)'(gcd_pkg::RECIP_ODD);
            r_mag   <= i_mag;
            r_neg1  <= i_neg;
            r_a     <= w_a;
            r_b     <= w_b;
            r_neg2  <= r_neg1;
            r_phase <= (PW'(r_a) << LS) + w_tbl[r_b];
            r_neg3  <= r_neg2;
        end
    end

    assign o_phase = r_phase;
    assign o_neg   = r_neg3;
endmodule

/* src/gcd_rot_cell.sv */
// one rotation-mode cordic micro-rotation, registered
// depends on gcd_pkg
module gcd_rot_cell #(
    parameter int STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  gcd_pkg::t_rot i_d,
    output gcd_pkg::t_rot o_d
);
    localparam int ZW = gcd_pkg::ZW;
    localparam int XW = gcd_pkg::XW;
    localparam logic signed [ZW-1:0] ATAN = ZW'(gcd_pkg::atan_phase(STAGE));

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    gcd_pkg::t_rot        n_d;
    gcd_pkg::t_rot        r_d;

    assign w_dx = i_d.y >>> STAGE;
    assign w_dy = i_d.x >>> STAGE;

    always_comb begin
        n_d = i_d;
        if (!i_d.z[ZW-1]) begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - ATAN;
        end else begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

/* src/gcd_sqrt_cell.sv */
// one digit step of the integer square root of 2^60 - c^2
// depends on gcd_pkg
module gcd_sqrt_cell #(
    parameter int K = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  gcd_pkg::t_sqr i_d,
    output gcd_pkg::t_sqr o_d
);
    localparam int SW = gcd_pkg::SQ_W;
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);

    logic [SW-1:0] w_cand;
    gcd_pkg::t_sqr n_d;
    gcd_pkg::t_sqr r_d;

    assign w_cand = i_d.r + BIT;

    always_comb begin
        n_d = i_d;
        if (i_d.n >= w_cand) begin
            n_d.n = i_d.n - w_cand;
            n_d.r = (i_d.r >> 1) + BIT;
        end else begin
            n_d.r = i_d.r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

/* src/gcd_vec_cell.sv */
// one vectoring-mode cordic micro-rotation for acos, registered
// depends on gcd_pkg
module gcd_vec_cell #(
    parameter int STAGE = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  gcd_pkg::t_vec i_d,
    output gcd_pkg::t_vec o_d
);
    localparam int ZW = gcd_pkg::ZW;
    localparam int XW = gcd_pkg::XW;
    localparam logic signed [ZW-1:0] ATAN = ZW'(gcd_pkg::atan_phase(STAGE));

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic                 w_pos;
    gcd_pkg::t_vec        n_d;
    gcd_pkg::t_vec        r_d;

    assign w_dx  = i_d.y >>> STAGE;
    assign w_dy  = i_d.x >>> STAGE;
    assign w_pos = !i_d.y[XW-1] && (i_d.y != '0);

    always_comb begin
        if (w_pos) begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + ATAN;
        end else begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

/* src/great_circle_distance_core.sv */
// great-circle distance core: one beat per cycle sustained while the skid stage is empty,
// the rate set by the fully unrolled cell chains (phase conversion, two cordics, square
// root); a beat held in the skid stage stalls the whole chain
// reset is synchronous: clears the valid line, output and skid valids, own position to zero
// no memories, so no clearing pass; an output register plus a skid stage part the channels
module great_circle_distance_core #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = gcd_pkg::CORDIC_STAGES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [0:0]                         i_cfg_index,
    input  logic [gcd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [gcd_pkg::LAT_W-1:0]   i_other_latitude,
    input  logic signed [gcd_pkg::LNG_W-1:0]   i_other_longitude,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gcd_pkg::DIST_W-1:0]         o_distance_m
);
    localparam int DEG_W  = gcd_pkg::DEG_W;
    localparam int MAG_W  = gcd_pkg::MAG_W;
    localparam int PW     = gcd_pkg::PHASE_W;
    localparam int XW     = gcd_pkg::XW;
    localparam int ZW     = gcd_pkg::ZW;
    localparam int TW     = gcd_pkg::TRIG_W;
    localparam int SW     = gcd_pkg::SQ_W;
    localparam int DW     = gcd_pkg::DIST_W;
    localparam int CS     = CORDIC_STAGES;
    localparam int NSQ    = gcd_pkg::SQRT_STEPS;
    // scale from degree units to phase units ahead of the divide by 360
    localparam int SH     = 32 - ANGLE_FRAC_BITS;
    // registered stages: in0, in1, conv x3, prep, trig, p1, p2, clamp, square, vec-in,
    // scale = 13
    localparam int LAT    = 2 * CS + NSQ + 13;

    localparam logic signed [34:0] POS_ONE = 35'(gcd_pkg::ONE_Q30);
    localparam logic signed [34:0] NEG_ONE = -35'(gcd_pkg::ONE_Q30);
    localparam logic [SW-1:0]      ONE_SQ  = SW'(1) << 60;
    localparam logic [32:0]        HALF_PI = 33'(gcd_pkg::ONE_Q30);
    localparam logic [32:0]        PI_PH   = 33'(gcd_pkg::ONE_Q30) << 1;

    // own position registers
    logic signed [gcd_pkg::LAT_W-1:0] r_own_lat;
    logic signed [gcd_pkg::LNG_W-1:0] r_own_lng;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_lat <= '0;
            r_own_lng <= '0;
        end else if (i_cfg_we) begin
            case (gcd_pkg::t_cfg_idx'(i_cfg_index))
                gcd_pkg::CFG_OWN_LATITUDE:  r_own_lat <= i_cfg_data[gcd_pkg::LAT_W-1:0];
                gcd_pkg::CFG_OWN_LONGITUDE: r_own_lng <= i_cfg_data[gcd_pkg::LNG_W-1:0];
                default: ;
            endcase
        end
    end

    // whole chain advances together unless the skid stage is holding a beat
    logic w_en;
    logic w_in_take;
    logic r_skid_valid;
    logic r_out_valid;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;
    assign w_in_take  = i_in_valid && w_en;

    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_in_take};
        end
    end

    // in0: channel 0 own latitude, 1 other latitude, 2 longitude difference
    logic signed [DEG_W-1:0] r_deg [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_deg[0] <= DEG_W'(r_own_lat);
            r_deg[1] <= DEG_W'(i_other_latitude);
            r_deg[2] <= DEG_W'(r_own_lng) - DEG_W'(i_other_longitude);
        end
    end

    // in1: magnitude and sign
    logic [MAG_W-1:0] r_mag [3];
    logic             r_neg [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_neg[ch] <= r_deg[ch][DEG_W-1];
                r_mag[ch] <= r_deg[ch][DEG_W-1] ? MAG_W'(-r_deg[ch]) : MAG_W'(r_deg[ch]);
            end
        end
    end

    // conversion to binary phase, rounded half away; the quotient keeps its low 32 bits
    logic [PW-1:0] w_quo [3];
    logic          w_neg [3];

    for (genvar ch = 0; ch < 3; ch++) begin : g_div
        gcd_div_cell #(.SH(SH)) u_conv (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_mag   (r_mag[ch]),
            .i_neg   (r_neg[ch]),
            .o_phase (w_quo[ch]),
            .o_neg   (w_neg[ch])
        );
    end

    // prep: signed phase, fold the left half-plane by a half turn
    gcd_pkg::t_rot r_prep [3];
    logic [PW-1:0] w_phase [3];
    logic          w_flip  [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_phase[ch] = w_neg[ch] ? (~w_quo[ch] + PW'(1)) : w_quo[ch];
            w_flip[ch]  = w_phase[ch][PW-1] ^ w_phase[ch][PW-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_prep[ch].x    <= XW'(gcd_pkg::GAIN_Q30);
                r_prep[ch].y    <= '0;
                r_prep[ch].z    <= ZW'($signed({w_phase[ch][PW-1] ^ w_flip[ch],
                                                w_phase[ch][PW-2:0]}));
                r_prep[ch].flip <= w_flip[ch];
            end
        end
    end

    // sine/cosine rotation chains
    gcd_pkg::t_rot w_rot [3][CS+1];

    for (genvar ch = 0; ch < 3; ch++) begin : g_rot
        assign w_rot[ch][0] = r_prep[ch];
        for (genvar k = 0; k < CS; k++) begin : g_cell
            gcd_rot_cell #(.STAGE(k)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_rot[ch][k]),
                .o_d   (w_rot[ch][k+1])
            );
        end
    end

    // trig: undo the half-turn fold
    logic signed [TW-1:0] r_sin_a, r_sin_b, r_cos_a, r_cos_b, r_cos_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sin_a <= TW'(w_rot[0][CS].flip ? -w_rot[0][CS].y : w_rot[0][CS].y);
            r_cos_a <= TW'(w_rot[0][CS].flip ? -w_rot[0][CS].x : w_rot[0][CS].x);
            r_sin_b <= TW'(w_rot[1][CS].flip ? -w_rot[1][CS].y : w_rot[1][CS].y);
            r_cos_b <= TW'(w_rot[1][CS].flip ? -w_rot[1][CS].x : w_rot[1][CS].x);
            r_cos_d <= TW'(w_rot[2][CS].flip ? -w_rot[2][CS].x : w_rot[2][CS].x);
        end
    end

    // p1, p2, clamp: c = sa*sb + (ca*cb)*cd in q2.30, floor at each shift
    logic signed [63:0]   r_p1;
    logic signed [63:0]   r_p2;
    logic signed [TW-1:0] r_cd2;
    logic signed [33:0]   r_s1;
    logic signed [63:0]   r_m;
    logic signed [TW-1:0] w_t;
    logic signed [34:0]   w_sum;
    logic signed [TW-1:0] r_c;

    assign w_t   = TW'(r_p2 >>> 30);
    assign w_sum = 35'(r_s1) + 35'(r_m >>> 30);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1  <= r_sin_a * r_sin_b;
            r_p2  <= r_cos_a * r_cos_b;
            r_cd2 <= r_cos_d;
            r_s1  <= 34'(r_p1 >>> 30);
            r_m   <= w_t * r_cd2;
            if (w_sum > POS_ONE) begin
                r_c <= TW'(POS_ONE);
            end else if (w_sum < NEG_ONE) begin
                r_c <= TW'(NEG_ONE);
            end else begin
                r_c <= TW'(w_sum);
            end
        end
    end

    // square: 2^60 - c^2 for the sine of the arc
    logic signed [63:0] w_csq;
    gcd_pkg::t_sqr      r_sq;

    assign w_csq = r_c * r_c;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq.n <= ONE_SQ - SW'(w_csq);
            r_sq.r <= '0;
            r_sq.c <= r_c;
        end
    end

    // square root chain, digit 4^30 down to 4^0
    gcd_pkg::t_sqr w_sqr [NSQ+1];

    assign w_sqr[0] = r_sq;
    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        gcd_sqrt_cell #(.K(NSQ - 1 - j)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sqr[j]),
            .o_d   (w_sqr[j+1])
        );
    end

    // vec-in: negative cosine starts a quarter turn on
    gcd_pkg::t_vec r_vin;
    logic          w_cneg;

    assign w_cneg = w_sqr[NSQ].c[TW-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_cneg) begin
                r_vin.x <= XW'(w_sqr[NSQ].r);
                r_vin.y <= -XW'(w_sqr[NSQ].c);
                r_vin.z <= ZW'(gcd_pkg::ONE_Q30);
            end else begin
                r_vin.x <= XW'(w_sqr[NSQ].c);
                r_vin.y <= XW'(w_sqr[NSQ].r);
                r_vin.z <= '0;
            end
        end
    end

    // acos vectoring chain
    gcd_pkg::t_vec w_vec [CS+1];

    assign w_vec[0] = r_vin;
    for (genvar k = 0; k < CS; k++) begin : g_vec
        gcd_vec_cell #(.STAGE(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_vec[k]),
            .o_d   (w_vec[k+1])
        );
    end

    // scale: clamp arc to [0, half turn] and multiply by the circumference
    logic signed [ZW-1:0]       w_z;
    logic [31:0]                w_zc;
    logic [gcd_pkg::PROD_W-1:0] r_prod;

    assign w_z = w_vec[CS].z;

    always_comb begin
        if (w_z[ZW-1]) begin
            w_zc = '0;
        end else if (w_z > $signed(ZW'(PI_PH))) begin
            w_zc = PI_PH[31:0];
        end else begin
            w_zc = w_z[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= w_zc * gcd_pkg::CIRCUMFERENCE_M;
        end
    end

    // round to metres and saturate at half circumference
    logic [gcd_pkg::PROD_W:0] w_round;
    logic [26:0]              w_metres;
    logic [DW-1:0]            w_dist;

    assign w_round  = (gcd_pkg::PROD_W+1)'(r_prod) + (gcd_pkg::PROD_W+1)'(HALF_PI) * 2;
    assign w_metres = w_round[gcd_pkg::PROD_W:32];
    assign w_dist   = (w_metres > 27'(gcd_pkg::MAX_DISTANCE_M)) ?
                      gcd_pkg::MAX_DISTANCE_M : w_metres[DW-1:0];

    // output register and skid stage
    logic [DW-1:0] r_out_dist;
    logic [DW-1:0] r_skid_dist;
    logic          w_take;
    logic          w_exit;

    assign w_take = r_out_valid && i_out_ready;
    assign w_exit = w_en && r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out_dist   <= r_skid_dist;
                r_skid_valid <= 1'b0;
            end
        end else if (w_exit) begin
            if (!r_out_valid || w_take) begin
                r_out_dist  <= w_dist;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_dist  <= w_dist;
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_distance_m = r_out_dist;

    // skid only ever fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while the output register is empty");

    // a beat leaving the chain into a stalled full output lands in the skid
    a_exit_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("beat lost at the chain exit");

    // accepted beat enters the valid line
    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted beat not tracked");

    // distance never beyond half circumference
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_distance_m <= gcd_pkg::MAX_DISTANCE_M))
        else $error("distance out of range");

endmodule

/* tb/great_circle_distance_core_tb.sv */
// self-checking testbench for the great-circle distance core: random and directed positions
// against an integer cordic predictor; depends on gcd_pkg and great_circle_distance_core
`timescale 1ns / 100ps

module great_circle_distance_core_tb;

    localparam int LATENCY   = 93;
    localparam int CYCLE_CAP = 400000;
    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam longint CIRC_M   = 64'sd40030174;
    localparam longint MAX_DIST = 64'sd20015087;

    // atan(2^-i) as binary phase, full turn = 2^32
    localparam logic [31:0] ATAN_TBL [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct {
        logic signed [gcd_pkg::LAT_W-1:0] lat;
        logic signed [gcd_pkg::LNG_W-1:0] lng;
    } t_point;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [0:0]                       i_cfg_index;
    logic [gcd_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic signed [gcd_pkg::LAT_W-1:0] i_other_latitude;
    logic signed [gcd_pkg::LNG_W-1:0] i_other_longitude;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [gcd_pkg::DIST_W-1:0]       o_distance_m;

    great_circle_distance_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_other_latitude  (i_other_latitude),
        .i_other_longitude (i_other_longitude),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_distance_m      (o_distance_m)
    );

    // own position as the predictor sees it
    logic signed [gcd_pkg::LAT_W-1:0] own_lat;
    logic signed [gcd_pkg::LNG_W-1:0] own_lng;

    t_point                     pending_points[$];
    logic [gcd_pkg::DIST_W-1:0] expected_dist[$];

    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;
    bit  in_taken;

    // ---------------- predictor ----------------

    // degree units to 32-bit binary phase, round half away from zero
    function automatic logic [31:0] angle_to_phase(input longint deg);
        longint unsigned mag, den, q;
        logic [31:0] p;
        mag = (deg < 0) ? longint'(-deg) : longint'(deg);
        den = 64'd360 << gcd_pkg::ANGLE_FRAC_BITS;
        q = ((mag << 32) + (64'd180 << gcd_pkg::ANGLE_FRAC_BITS)) / den;
        p = q[31:0];
        return (deg < 0) ? 32'd0 - p : p;
    endfunction

    // rotation cordic; second and third quadrants folded through a half turn
    function automatic void cordic_sincos(input logic [31:0] ph_in,
                                          output longint s, output longint c);
        longint x, y, z, dx, dy;
        logic [31:0] ph;
        bit flip;
        ph = ph_in;
        flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
        if (flip) ph = ph ^ 32'h80000000;
        x = 64'sd652032875;
        y = 0;
        z = longint'($signed(ph));
        for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint unsigned isqrt_u64(input longint unsigned n_in);
        longint unsigned n, r, b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // acos as atan2(sqrt(1-c^2), c) by vectoring cordic, result in binary phase
    function automatic longint arccos_phase(input longint c);
        longint x, y, z, t, dx, dy;
        x = c;
        z = 0;
        y = longint'(isqrt_u64(longint'(ONE_Q30 * ONE_Q30 - c * c)));
        if (x < 0) begin
            t = x; x = y; y = -t;
            z = ONE_Q30;
        end
        for (int i = 0; i < gcd_pkg::CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > 2 * ONE_Q30) z = 2 * ONE_Q30;
        return z;
    endfunction

    function automatic logic [gcd_pkg::DIST_W-1:0] predict_distance(input t_point p);
        longint sa, ca, sb, cb, sd, cd, c, z, d;
        cordic_sincos(angle_to_phase(longint'(own_lat)), sa, ca);
        cordic_sincos(angle_to_phase(longint'(p.lat)), sb, cb);
        cordic_sincos(angle_to_phase(longint'(own_lng) - longint'(p.lng)), sd, cd);
        c = ((sa * sb) >>> 30) + ((((ca * cb) >>> 30) * cd) >>> 30);
        if (c > ONE_Q30) c = ONE_Q30;
        if (c < -ONE_Q30) c = -ONE_Q30;
        z = arccos_phase(c);
        d = (z * CIRC_M + (64'sd1 << 31)) >>> 32;
        if (d > MAX_DIST) d = MAX_DIST;
        return d[gcd_pkg::DIST_W-1:0];
    endfunction

    // ---------------- clock, reset, timeout ----------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout at %0t", $time);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- input driver ----------------

    // at the rising edge note the accepted beat and predict its distance
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            in_taken = 1'b1;
            expected_dist.push_back(predict_distance(
                '{lat: i_other_latitude, lng: i_other_longitude}));
        end
    end

    // payload moves only at the falling edge, valid held until the beat is taken
    always @(negedge i_clk) begin
        t_point p;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                p = pending_points.pop_front();
                i_in_valid        <= 1'b1;
                i_other_latitude  <= p.lat;
                i_other_longitude <= p.lng;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------- output side ----------------

    // receiver ready, with an optional long hold-off so the pipe backs up
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [gcd_pkg::DIST_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_dist.size() == 0) begin
                $display("%0t: unexpected distance beat, actual %0d", $time, o_distance_m);
                errors++;
            end else begin
                want = expected_dist.pop_front();
                if (o_distance_m !== want) begin
                    $display("%0t: distance mismatch, expected %0d actual %0d",
                             $time, want, o_distance_m);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic signed [gcd_pkg::LAT_W-1:0] rand_lat();
        if ($urandom_range(9) == 0) return gcd_pkg::LAT_W'($urandom());   // any bit pattern
        return gcd_pkg::LAT_W'($urandom_range(11796480) - 5898240);
    endfunction

    function automatic logic signed [gcd_pkg::LNG_W-1:0] rand_lng();
        if ($urandom_range(9) == 0) return gcd_pkg::LNG_W'($urandom());
        return gcd_pkg::LNG_W'($urandom_range(23592960) - 11796480);
    endfunction

    task automatic add_point(input int lat, input int lng);
        pending_points.push_back('{lat: gcd_pkg::LAT_W'(lat), lng: gcd_pkg::LNG_W'(lng)});
    endtask

    // wait until every beat has gone through and the pipe is empty
    task automatic drain();
        while (pending_points.size() > 0 || i_in_valid || expected_dist.size() > 0)
            @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
    endtask

    task automatic write_reg(input gcd_pkg::t_cfg_idx idx, input logic [24:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == gcd_pkg::CFG_OWN_LATITUDE) own_lat = val[gcd_pkg::LAT_W-1:0];
        else own_lng = val;
    endtask

    task automatic set_position(input logic [24:0] lat, input logic [24:0] lng);
        write_reg(gcd_pkg::CFG_OWN_LATITUDE, lat);
        write_reg(gcd_pkg::CFG_OWN_LONGITUDE, lng);
    endtask

    task automatic random_phase(input int n, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int k = 0; k < n; k++) begin
            // one point in four nearby, where the cosine sits close to one
            if ($urandom_range(3) == 0)
                add_point(own_lat + $urandom_range(2000) - 1000,
                          own_lng + $urandom_range(2000) - 1000);
            else
                add_point(rand_lat(), rand_lng());
        end
        drain();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = gcd_pkg::CFG_OWN_LATITUDE;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_other_latitude  = '0;
        i_other_longitude = '0;
        i_out_ready       = 1'b0;
        own_lat           = '0;
        own_lng           = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset position, field extremes, poles, antipodes, wrapping patterns
        add_point(0, 0);                       // same point, zero distance
        add_point(0, 11796480);                // antipode on the equator
        add_point(0, -11796480);
        add_point(5898240, 0);                 // north pole
        add_point(-5898240, 0);                // south pole
        add_point(5898240, 11796480);
        add_point(-5898240, -11796480);
        add_point(-8388608, -16777216);        // most negative bit patterns
        add_point(8388607, 16777215);          // most positive bit patterns
        add_point(1, -1);
        add_point(0, 5898240);
        add_point(-1, 0);
        drain();

        // own position at an extreme, then the opposite extreme
        set_position(25'd5898240, 25'd11796480);
        add_point(5898240, 11796480);
        add_point(-5898240, -11796480);
        add_point(0, 0);
        add_point(5898239, 11796479);
        drain();
        set_position(-25'sd5898240, -25'sd11796480);
        add_point(5898240, 11796480);
        add_point(-5898240, -11796480);
        add_point(0, 0);
        drain();
        set_position(25'h1800000, 25'h1000000);  // wrapping register patterns
        add_point(0, 0);
        add_point(-8388608, -16777216);
        drain();

        // random phases under several idling mixes
        set_position(25'd3000000, -25'sd500000);
        random_phase(70, 0, 0);
        set_position(25'($urandom()), 25'($urandom()));
        random_phase(55, 56, 0);
        set_position(25'($urandom_range(11796480) - 5898240),
                     25'($urandom_range(23592960) - 11796480));
        random_phase(55, 0, 56);
        set_position(0, 0);
        random_phase(55, 34, 34);

        // long receiver hold-off while the sender keeps offering beats
        set_position(-25'sd1234567, 25'd7654321);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 400;
        for (int k = 0; k < 200; k++) add_point(rand_lat(), rand_lng());
        drain();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
